### hdl/merge_sort_engine_defines.svh
// ----------------------------------------------------------------------------
// merge_sort_engine_defines
// Assertion macros used by the merge sort engine port checker (mse_checker).
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

// ante holds at an edge, so cons holds at the next edge
`define MSE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("merge sort engine: next-cycle check failed");

// ante holds at an edge, so cons holds at the same edge
`define MSE_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("merge sort engine: same-cycle check failed");

`endif

### hdl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants and types of the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  // room for pointer + twice the run width
  localparam int SUM_W        = CNT_W + 2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETUP,
    ST_MERGE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;   // input transfer this cycle
    logic setup;  // prepare a pass (or the output scan)
    logic merge;  // one merge step
    logic emit;   // drive results
  } cmd_t;

  typedef struct packed {
    logic in_last;    // current input flags end of set
    logic pass_end;   // last element of a pass written this cycle
    logic sort_done;  // run width covers the whole set
    logic out_done;   // all results handed to the output register
  } status_t;

endpackage

### hdl/mse_in_if.sv
// ----------------------------------------------------------------------------
// mse_in_if
// Input channel: one value to sort per transfer, plus the end-of-set flag.
// ----------------------------------------------------------------------------
interface mse_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mse_pkg::DATA_W-1:0]    element_value;
  logic                                 is_last;

  modport source (output valid, output element_value, output is_last, input ready);
  modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

### hdl/mse_out_if.sv
// ----------------------------------------------------------------------------
// mse_out_if
// Output channel: sorted values in ascending order, final one flagged.
// ----------------------------------------------------------------------------
interface mse_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mse_pkg::DATA_W-1:0]    sorted_value;
  logic                                 last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

### hdl/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

### hdl/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer: load, per-pass setup, merge passes, result scan.
// ----------------------------------------------------------------------------
module mse_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mse_pkg::status_t status_i,
  output mse_pkg::cmd_t    cmd_o
);
  import mse_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && status_i.in_last) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = status_i.sort_done ? ST_OUT : ST_MERGE;
      end
      ST_MERGE: begin
        if (status_i.pass_end) begin
          state_d = ST_SETUP;
        end
      end
      ST_OUT: begin
        if (status_i.out_done) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SETUP: cmd_o.setup = 1'b1;
      ST_MERGE: cmd_o.merge = 1'b1;
      ST_OUT:   cmd_o.emit  = 1'b1;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### hdl/mse_dp.sv
// ----------------------------------------------------------------------------
// mse_dp
// Datapath: ping-pong value buffers, merge pointers, output register.
// ----------------------------------------------------------------------------
module mse_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [mse_pkg::DATA_W-1:0] element_value_i,
  input  logic                              is_last_i,
  input  mse_pkg::cmd_t                     cmd_i,
  output mse_pkg::status_t                  status_o,
  mse_out_if.source                         out_o
);
  import mse_pkg::*;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  a_q, a_d, b_q, b_d, k_q, k_d, mid_q, mid_d, hi_q, hi_d;
  logic [SUM_W-1:0]  w_q, w_d;
  logic              src_q, src_d;
  logic              ov_q, ov_d;
  logic [DATA_W-1:0] od_q, od_d;
  logic              ol_q, ol_d;

  logic              we0, we1;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] r0a, r0b, r1a, r1b, va, vb;
  logic [SUM_W-1:0]  n_ext, w_dbl, s_mid, s_hi, sum_mid, sum_hi, nx_mid, nx_hi;
  logic [CNT_W-1:0]  k_inc, a_inc;
  logic              room, take_a, ld;

  // buffer 0 holds the loaded set; passes alternate between the buffers
  mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_ram0 (
    .clk_i    (clk_i),
    .we_i     (we0),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (a_d[IDX_W-1:0]),
    .raddr1_i (b_d[IDX_W-1:0]),
    .rdata0_o (r0a),
    .rdata1_o (r0b)
  );

  mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_ram1 (
    .clk_i    (clk_i),
    .we_i     (we1),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (a_d[IDX_W-1:0]),
    .raddr1_i (b_d[IDX_W-1:0]),
    .rdata0_o (r1a),
    .rdata1_o (r1b)
  );

  assign va = src_q ? r1a : r0a;
  assign vb = src_q ? r1b : r0b;

  assign n_ext   = SUM_W'(cnt_q);
  assign w_dbl   = w_q << 1;
  assign s_mid   = (w_q   < n_ext) ? w_q   : n_ext;
  assign s_hi    = (w_dbl < n_ext) ? w_dbl : n_ext;
  assign sum_mid = SUM_W'(hi_q) + w_q;
  assign sum_hi  = SUM_W'(hi_q) + w_dbl;
  assign nx_mid  = (sum_mid < n_ext) ? sum_mid : n_ext;
  assign nx_hi   = (sum_hi  < n_ext) ? sum_hi  : n_ext;
  assign k_inc   = k_q + CNT_W'(1);
  assign a_inc   = a_q + CNT_W'(1);

  assign room   = cnt_q < CNT_W'(MAX_ELEMENTS);
  // left run wins on ties
  assign take_a = (a_q < mid_q) && ((b_q >= hi_q) || ($signed(va) <= $signed(vb)));

  assign we0   = (cmd_i.load && room) || (cmd_i.merge && src_q);
  assign we1   = cmd_i.merge && !src_q;
  assign waddr = cmd_i.merge ? k_q[IDX_W-1:0] : cnt_q[IDX_W-1:0];
  assign wdata = cmd_i.merge ? (take_a ? va : vb) : element_value_i;

  assign ld = cmd_i.emit && (a_q < cnt_q) && (!ov_q || out_o.ready);

  assign status_o.in_last   = is_last_i;
  assign status_o.pass_end  = cmd_i.merge && (k_inc == cnt_q);
  assign status_o.sort_done = w_q >= n_ext;
  assign status_o.out_done  = a_q == cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    a_d   = a_q;
    b_d   = b_q;
    k_d   = k_q;
    mid_d = mid_q;
    hi_d  = hi_q;
    w_d   = w_q;
    src_d = src_q;
    ov_d  = ov_q;
    od_d  = od_q;
    ol_d  = ol_q;

    if (cmd_i.load) begin
      if (room) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (is_last_i) begin
        w_d   = SUM_W'(1);
        src_d = 1'b0;
      end
    end

    if (cmd_i.setup) begin
      a_d   = '0;
      k_d   = '0;
      mid_d = CNT_W'(s_mid);
      b_d   = CNT_W'(s_mid);
      hi_d  = CNT_W'(s_hi);
    end

    if (cmd_i.merge) begin
      k_d = k_inc;
      if (take_a) begin
        a_d = a_inc;
      end else begin
        b_d = b_q + CNT_W'(1);
      end
      if (k_inc == hi_q) begin
        a_d   = hi_q;
        mid_d = CNT_W'(nx_mid);
        b_d   = CNT_W'(nx_mid);
        hi_d  = CNT_W'(nx_hi);
      end
      if (k_inc == cnt_q) begin
        w_d   = w_dbl;
        src_d = !src_q;
      end
    end

    // output register; a_q doubles as the scan index
    if (ld) begin
      ov_d = 1'b1;
      od_d = va;
      ol_d = (a_inc == cnt_q);
      a_d  = a_inc;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end

    if (cmd_i.emit && (a_q == cnt_q)) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      a_q   <= '0;
      b_q   <= '0;
      k_q   <= '0;
      mid_q <= '0;
      hi_q  <= '0;
      w_q   <= '0;
      src_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      a_q   <= a_d;
      b_q   <= b_d;
      k_q   <= k_d;
      mid_q <= mid_d;
      hi_q  <= hi_d;
      w_q   <= w_d;
      src_q <= src_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    ol_q <= ol_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.sorted_value = od_q;
  assign out_o.last_out     = ol_q;

endmodule

### hdl/merge_sort_engine.sv
// ----------------------------------------------------------------------------
// merge_sort_engine
// Collects a set of signed values, merge sorts them, streams them out.
// ----------------------------------------------------------------------------
//  channel | dir | payload                        | transfer when
//  in_i    | in  | element_value[31:0], is_last   | in_i.valid & in_i.ready
//  out_o   | out | sorted_value[31:0], last_out   | out_o.valid & out_o.ready
//
//  Load: one transfer per cycle; values past the buffer depth are dropped.
//  Sort: ceil(log2 n) bottom-up passes, each a setup step and then a merge
//  of all n elements (one element per cycle through the two-read-port
//  buffers), then a last setup step before the result scan.
//  Output: n results at one per cycle while the sink is ready; the input
//  reopens after the last result has entered the output register.
//  Reset is asynchronous and clears control only; no clearing pass.
// ----------------------------------------------------------------------------
module merge_sort_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  mse_in_if.sink    in_i,
  mse_out_if.source out_o
);
  import mse_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: owns in_i.ready and steps the datapath
  mse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // buffers, merge pointers and the output register
  mse_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_value_i (in_i.element_value),
    .is_last_i       (in_i.is_last),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_o           (out_o)
  );

endmodule

### hdl/mse_checker.sv
// ----------------------------------------------------------------------------
// mse_checker
// Port-level checks of the merge sort engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "merge_sort_engine_defines.svh"

module mse_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_last_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [mse_pkg::DATA_W-1:0] out_value_i,
  input logic                      out_last_i
);

  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // stalled result holds
  `MSE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_value_i) && $stable(out_last_i))
  // closing a set stops intake for the sort
  `MSE_ASSERT_NEXT(a_close_stops_in, clk_i, rst_ni, in_xfer && in_last_i, !in_ready_i)
  // a set still open keeps intake going
  `MSE_ASSERT_NEXT(a_open_keeps_in, clk_i, rst_ni, in_xfer && !in_last_i, in_ready_i)
  // mid-set result: scan still running, so intake stays closed
  `MSE_ASSERT_NEXT(a_mid_out_no_in, clk_i, rst_ni, out_xfer && !out_last_i, !in_ready_i)

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.is_last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.sorted_value),
  .out_last_i  (out_o.last_out)
);

### bench/merge_sort_engine_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merge_sort_engine_checker
// Watches both channels of the merge sort engine. It keeps its own copy of
// the loaded set, sorts it when the set closes, and compares every output
// transfer against the oldest sorted value still owed.
// ----------------------------------------------------------------------------
module merge_sort_engine_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mse_in_if    in_mon,
  mse_out_if   out_mon,
  output int   fail_cnt_o,
  output int   owed_cnt_o
);

  import mse_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } sorted_rec_t;

  logic signed [DATA_W-1:0] held_vals [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] merge_buf [MAX_ELEMENTS];
  int                       held_cnt;
  sorted_rec_t              owed_q [$];

  // Stable bottom-up merge sort of held_vals[0 .. n-1]; left run wins ties.
  function automatic void sort_held(int n);
    int w;
    int lo;
    int mid;
    int hi;
    int a;
    int b;
    int k;
    for (w = 1; w < n; w = w * 2) begin
      for (lo = 0; lo + w < n; lo = lo + 2 * w) begin
        mid = lo + w;
        hi  = (mid + w > n) ? n : mid + w;
        a   = lo;
        b   = mid;
        k   = lo;
        while (a < mid && b < hi) begin
          if (held_vals[a] <= held_vals[b]) begin
            merge_buf[k] = held_vals[a];
            a = a + 1;
          end else begin
            merge_buf[k] = held_vals[b];
            b = b + 1;
          end
          k = k + 1;
        end
        while (a < mid) begin
          merge_buf[k] = held_vals[a];
          a = a + 1;
          k = k + 1;
        end
        while (b < hi) begin
          merge_buf[k] = held_vals[b];
          b = b + 1;
          k = k + 1;
        end
        for (k = lo; k < hi; k++) held_vals[k] = merge_buf[k];
      end
    end
  endfunction

  function automatic void note_fail(string msg);
    if (fail_cnt_o < 10) $display("[%0t] mismatch: %s", $realtime, msg);
    fail_cnt_o = fail_cnt_o + 1;
  endfunction

  initial begin
    fail_cnt_o = 0;
    owed_cnt_o = 0;
    held_cnt   = 0;
  end

  always @(posedge clk_i) begin
    sorted_rec_t exp_rec;
    if (rst_ni) begin
      // output side first: a set closed at this edge cannot emit at this edge
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          note_fail($sformatf("unexpected result value=%0d last=%0b",
                              out_mon.sorted_value, out_mon.last_out));
        end else begin
          exp_rec = owed_q.pop_front();
          if (out_mon.sorted_value !== exp_rec.value)
            note_fail($sformatf("sorted_value exp=%0d got=%0d",
                                exp_rec.value, out_mon.sorted_value));
          if (out_mon.last_out !== exp_rec.last)
            note_fail($sformatf("last_out exp=%0b got=%0b (value %0d)",
                                exp_rec.last, out_mon.last_out, exp_rec.value));
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        // values past capacity are dropped, a dropped last still closes the set
        if (held_cnt < MAX_ELEMENTS) begin
          held_vals[held_cnt] = in_mon.element_value;
          held_cnt = held_cnt + 1;
        end
        if (in_mon.is_last) begin
          sort_held(held_cnt);
          for (int i = 0; i < held_cnt; i++) begin
            exp_rec.value = held_vals[i];
            exp_rec.last  = (i == held_cnt - 1);
            owed_q.push_back(exp_rec);
          end
          held_cnt = 0;
        end
      end
      owed_cnt_o = owed_q.size();
    end
  end

endmodule

### bench/merge_sort_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merge_sort_engine_tb
// Drives sets of signed values into the merge sort engine: a directed part
// with extremes, ties and reversed order, then random sets of mostly small
// size with a few full and overflowing sets. Both channels stall at random.
// A checker beside the block predicts and compares the sorted stream.
// ----------------------------------------------------------------------------
module merge_sort_engine_tb;

  import mse_pkg::*;

  localparam int ITEM_TARGET = 420;
  localparam int IDLE_PCT    = 14;
  // drain after the last owed result: output register plus a little slack
  localparam int DRAIN_CYC   = 50;
  // worst case per item: a 64-wide sort (6 passes) and stalled output;
  // far beyond any correct run
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic clk_i;
  logic rst_ni;
  int   cycle_cnt;
  int   items_sent;
  int   fail_cnt;
  int   owed_cnt;
  logic in_gaps_on;
  logic signed [DATA_W-1:0] set_q [$];

  mse_in_if  in_ch ();
  mse_out_if out_ch ();

  merge_sort_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  merge_sort_engine_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_cnt_o (fail_cnt),
    .owed_cnt_o (owed_cnt)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung engine or a lost result ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_cnt, owed_cnt);
      $display("** merge_sort_engine: FAILED **");
      $finish;
    end
  end

  // Sink side: ready drops about 14% of the time, except in a quiet window
  // where the output runs back to back.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (items_sent >= 100 && items_sent < 250)
        out_ch.ready <= 1'b1;
      else
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // One input transfer. Called right after a posedge (or after reset), so
  // every negedge below carries at most one update of valid.
  task automatic push_elem(input logic signed [DATA_W-1:0] v, input logic last);
    @(negedge clk_i);
    while (in_gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.element_value <= v;
    in_ch.is_last       <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Sends set_q as one set; the final entry carries is_last.
  task automatic push_set();
    for (int i = 0; i < set_q.size(); i++) push_elem(set_q[i], i == set_q.size() - 1);
    set_q.delete();
  endtask

  // Drop valid and hold off until every owed result has come out.
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (owed_cnt != 0) @(negedge clk_i);
  endtask

  // Mix of small values (lots of ties), extremes and full-range randoms.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 25) return $signed($urandom_range(8)) - 4;
    if (r < 30) return VAL_MIN;
    if (r < 35) return VAL_MAX;
    return $urandom;
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(16, 1);
    if (r < 90) return $urandom_range(MAX_ELEMENTS - 1, 17);
    if (r < 95) return MAX_ELEMENTS;
    // overflow: the excess, last included, is dropped by the engine
    return $urandom_range(MAX_ELEMENTS + 8, MAX_ELEMENTS + 1);
  endfunction

  initial begin
    int sz;
    logic pressed;
    cycle_cnt           = 0;
    items_sent          = 0;
    in_gaps_on          = 1'b1;
    pressed             = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.element_value = '0;
    in_ch.is_last       = 1'b0;
    rst_ni              = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // single-element set at the top of the range
    set_q = '{VAL_MAX};
    push_set();
    // extremes, zero and neighbors, duplicate minimum
    set_q = '{VAL_MIN, VAL_MAX, 0, -1, 1, VAL_MIN};
    push_set();
    // all equal: ties throughout
    set_q = '{5, 5, 5};
    push_set();
    // strictly descending, power-of-two size
    set_q = '{70, 60, 50, 40, 30, 20, 10, -10};
    push_set();
    // already ascending pair
    set_q = '{-2, 3};
    push_set();
    hold_until_drained();

    // --- random sets ---
    while (items_sent < ITEM_TARGET) begin
      // a stretch with no input gaps
      in_gaps_on = !(items_sent >= 150 && items_sent < 250);
      sz = pick_size();
      for (int i = 0; i < sz; i++) set_q.push_back(pick_value());
      push_set();
      if (!pressed && items_sent > 200) begin
        hold_until_drained();
        pressed = 1'b1;
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (fail_cnt == 0 && owed_cnt == 0)
      $display("** merge_sort_engine: PASSED **");
    else
      $display("** merge_sort_engine: FAILED **");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/mse_pkg.sv
hdl/mse_in_if.sv
hdl/mse_out_if.sv
hdl/mse_ram.sv
hdl/mse_ctrl.sv
hdl/mse_dp.sv
hdl/merge_sort_engine.sv
hdl/mse_checker.sv
bench/merge_sort_engine_checker.sv
bench/merge_sort_engine_tb.sv
